>>> sv/dtq_pkg.sv
// Package for the deadline timer queue: field widths, item and result codes,
// and the layout of one stored timer entry.
// Depends on nothing; imported by deadline_timer_queue.
package dtq_pkg;

  localparam int unsigned TIME_W  = 48;
  localparam int unsigned SEQ_W   = 32;
  localparam int unsigned DELAY_W = 32;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned RKIND_W = 3;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // Input item kinds
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

  // Result kinds
  localparam logic [RKIND_W-1:0] RK_ADDED     = 3'd0;
  localparam logic [RKIND_W-1:0] RK_REJECT    = 3'd1;
  localparam logic [RKIND_W-1:0] RK_FIRED     = 3'd2;
  localparam logic [RKIND_W-1:0] RK_CANCELLED = 3'd3;
  localparam logic [RKIND_W-1:0] RK_NOT_FOUND = 3'd4;
  localparam logic [RKIND_W-1:0] RK_SUMMARY   = 3'd5;

  // One timer slot as held in the entry memory
  typedef struct packed {
    logic              valid;
    logic              stopped;
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] deadline;
  } entry_t;

endpackage

>>> sv/deadline_timer_queue.sv
// Deadline timer queue: slot memory, scan sequencer and output register.
// Depends on dtq_pkg.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------------
//  in      | input     | in_valid_i/in_ready_o   | kind, now_ms, offset_ms, cancel_seq
//  out     | output    | out_valid_o/out_ready_i | result_kind, res_seq, deadline_ms,
//          |           |                         | armed, next_deadline_ms, last
//
// An add or cancel runs one scan of the slot memory through its single read port,
// one slot a cycle. A tick runs one scan, then one more for each due timer and one
// more for the summary. After reset a clearing pass invalidates every slot; no word
// is taken until it ends. A stalled output holds the sequencer in the step that
// wants to emit; a word is taken only while the sequencer is idle.
module deadline_timer_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [dtq_pkg::KIND_W-1:0]    kind_i,
  input  logic [dtq_pkg::TIME_W-1:0]    now_ms_i,
  input  logic [dtq_pkg::DELAY_W-1:0]   offset_ms_i,
  input  logic [dtq_pkg::SEQ_W-1:0]     cancel_seq_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dtq_pkg::RKIND_W-1:0]   result_kind_o,
  output logic [dtq_pkg::SEQ_W-1:0]     res_seq_o,
  output logic [dtq_pkg::TIME_W-1:0]    deadline_ms_o,
  output logic                          armed_o,
  output logic [dtq_pkg::TIME_W-1:0]    next_deadline_ms_o,
  output logic                          last_o
);
  import dtq_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned PW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
  localparam logic [PW-1:0] FULL_CNT = PW'(CAPACITY);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_DONE  = 6'b001000,
    ST_FSCAN = 6'b010000,
    ST_FHIT  = 6'b100000
  } state_e;

  // Control state
  state_e            state_q, state_d;
  logic [SEQ_W-1:0]  next_seq_q, next_seq_d;
  logic [PW-1:0]     pending_q, pending_d;
  logic [IW-1:0]     scan_idx_q, scan_idx_d;
  logic              issue_q, issue_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic              out_valid_q, out_valid_d;

  // Item and scan payload
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic [TIME_W-1:0] dl_q, dl_d;
  logic [SEQ_W-1:0]  cseq_q, cseq_d;
  logic [IW-1:0]     cmp_idx_q, cmp_idx_d;
  logic              best_vld_q, best_vld_d;
  logic [IW-1:0]     best_slot_q, best_slot_d;
  logic [TIME_W-1:0] best_dl_q, best_dl_d;
  logic [SEQ_W-1:0]  best_seq_q, best_seq_d;
  logic              best_stp_q, best_stp_d;
  logic              free_vld_q, free_vld_d;
  logic [IW-1:0]     free_slot_q, free_slot_d;
  logic              match_vld_q, match_vld_d;
  logic [IW-1:0]     match_slot_q, match_slot_d;
  logic [TIME_W-1:0] match_dl_q, match_dl_d;
  logic              sum_armed_q, sum_armed_d;
  logic [TIME_W-1:0] sum_next_q, sum_next_d;

  // Output register
  logic [RKIND_W-1:0] out_kind_q, out_kind_d;
  logic [SEQ_W-1:0]   out_seq_q, out_seq_d;
  logic [TIME_W-1:0]  out_dl_q, out_dl_d;
  logic               out_armed_q, out_armed_d;
  logic [TIME_W-1:0]  out_next_q, out_next_d;
  logic               out_last_q, out_last_d;

  // Slot memory
  entry_t            mem [CAPACITY];
  entry_t            rd_q;
  logic              mem_we;
  logic [IW-1:0]     mem_wa;
  entry_t            mem_wd;

  logic              in_acc, out_free, scanning, scan_end;
  logic [TIME_W:0]   add_sum;
  logic [TIME_W-1:0] add_dl;
  logic              due, cand, better, take;
  logic [TIME_W-1:0] cur_next;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign scanning   = (state_q == ST_SCAN) || (state_q == ST_FSCAN);
  assign scan_end   = cmp_vld_q && (cmp_idx_q == LAST_IDX);

  // Saturating deadline of a new timer
  assign add_sum = {1'b0, now_ms_i} + {{(TIME_W - DELAY_W + 1){1'b0}}, offset_ms_i};
  assign add_dl  = add_sum[TIME_W] ? TIME_MAX : add_sum[TIME_W-1:0];

  // Shared compare unit on the slot just read
  assign due = (rd_q.deadline <= now_q);
  always_comb begin
    if (state_q == ST_SCAN) begin
      // earliest timer left once the item is done
      cand   = rd_q.valid && ((kind_q != KIND_TICK) || !due);
      better = !best_vld_q || (rd_q.deadline < best_dl_q);
    end else begin
      // earliest due timer by deadline, then sequence
      cand   = rd_q.valid && due;
      better = !best_vld_q || (rd_q.deadline < best_dl_q) ||
               ((rd_q.deadline == best_dl_q) && (rd_q.seq < best_seq_q));
    end
    take = cmp_vld_q && cand && better;
  end

  assign cur_next = best_vld_q ? best_dl_q : '0;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    next_seq_d   = next_seq_q;
    pending_d    = pending_q;
    scan_idx_d   = scan_idx_q;
    issue_d      = issue_q;
    cmp_vld_d    = scanning && issue_q;
    cmp_idx_d    = scan_idx_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    kind_d       = kind_q;
    now_d        = now_q;
    dl_d         = dl_q;
    cseq_d       = cseq_q;
    best_vld_d   = best_vld_q;
    best_slot_d  = best_slot_q;
    best_dl_d    = best_dl_q;
    best_seq_d   = best_seq_q;
    best_stp_d   = best_stp_q;
    free_vld_d   = free_vld_q;
    free_slot_d  = free_slot_q;
    match_vld_d  = match_vld_q;
    match_slot_d = match_slot_q;
    match_dl_d   = match_dl_q;
    sum_armed_d  = sum_armed_q;
    sum_next_d   = sum_next_q;
    out_kind_d   = out_kind_q;
    out_seq_d    = out_seq_q;
    out_dl_d     = out_dl_q;
    out_armed_d  = out_armed_q;
    out_next_d   = out_next_q;
    out_last_d   = out_last_q;
    mem_we       = 1'b0;
    mem_wa       = scan_idx_q;
    mem_wd       = '0;

    // advance the read address through all slots
    if (scanning && issue_q) begin
      if (scan_idx_q == LAST_IDX) begin
        issue_d = 1'b0;
      end else begin
        scan_idx_d = scan_idx_q + IW'(1);
      end
    end

    // track the best candidate, first free slot and first sequence match
    if (take) begin
      best_vld_d  = 1'b1;
      best_slot_d = cmp_idx_q;
      best_dl_d   = rd_q.deadline;
      best_seq_d  = rd_q.seq;
      best_stp_d  = rd_q.stopped;
    end
    if (cmp_vld_q && (state_q == ST_SCAN)) begin
      if (!rd_q.valid && !free_vld_q) begin
        free_vld_d  = 1'b1;
        free_slot_d = cmp_idx_q;
      end
      if (rd_q.valid && (rd_q.seq == cseq_q) && !match_vld_q) begin
        match_vld_d  = 1'b1;
        match_slot_d = cmp_idx_q;
        match_dl_d   = rd_q.deadline;
      end
    end

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = scan_idx_q;
        mem_wd = '0;
        if (scan_idx_q == LAST_IDX) begin
          scan_idx_d = '0;
          state_d    = ST_IDLE;
        end else begin
          scan_idx_d = scan_idx_q + IW'(1);
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          kind_d = kind_i;
          now_d  = now_ms_i;
          dl_d   = add_dl;
          cseq_d = cancel_seq_i;
          if (kind_i inside {KIND_ADD, KIND_CANCEL, KIND_TICK}) begin
            scan_idx_d  = '0;
            issue_d     = 1'b1;
            best_vld_d  = 1'b0;
            free_vld_d  = 1'b0;
            match_vld_d = 1'b0;
            state_d     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        case (kind_q)
          KIND_TICK: begin
            // hold the summary, then drain due timers
            sum_armed_d = best_vld_q;
            sum_next_d  = cur_next;
            scan_idx_d  = '0;
            issue_d     = 1'b1;
            best_vld_d  = 1'b0;
            state_d     = ST_FSCAN;
          end
          KIND_ADD: begin
            if (out_free) begin
              out_valid_d = 1'b1;
              out_last_d  = 1'b1;
              if ((pending_q != FULL_CNT) && free_vld_q) begin
                mem_we      = 1'b1;
                mem_wa      = free_slot_q;
                mem_wd      = '{valid: 1'b1, stopped: 1'b0, seq: next_seq_q, deadline: dl_q};
                pending_d   = pending_q + PW'(1);
                next_seq_d  = next_seq_q + SEQ_W'(1);
                out_kind_d  = RK_ADDED;
                out_seq_d   = next_seq_q;
                out_dl_d    = dl_q;
                out_armed_d = 1'b1;
                out_next_d  = (best_vld_q && (best_dl_q < dl_q)) ? best_dl_q : dl_q;
              end else begin
                out_kind_d  = RK_REJECT;
                out_seq_d   = '0;
                out_dl_d    = '0;
                out_armed_d = best_vld_q;
                out_next_d  = cur_next;
              end
              state_d = ST_IDLE;
            end
          end
          KIND_CANCEL: begin
            if (out_free) begin
              out_valid_d = 1'b1;
              out_last_d  = 1'b1;
              out_seq_d   = cseq_q;
              out_dl_d    = '0;
              out_armed_d = best_vld_q;
              out_next_d  = cur_next;
              if (match_vld_q) begin
                mem_we     = 1'b1;
                mem_wa     = match_slot_q;
                mem_wd     = '{valid: 1'b1, stopped: 1'b1, seq: cseq_q, deadline: match_dl_q};
                out_kind_d = RK_CANCELLED;
              end else begin
                out_kind_d = RK_NOT_FOUND;
              end
              state_d = ST_IDLE;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_FSCAN: begin
        if (scan_end) begin
          state_d = ST_FHIT;
        end
      end
      ST_FHIT: begin
        if (out_free) begin
          out_armed_d = sum_armed_q;
          out_next_d  = sum_next_q;
          if (best_vld_q) begin
            // drop the earliest due timer, report it unless stopped
            mem_we = 1'b1;
            mem_wa = best_slot_q;
            mem_wd = '0;
            if (pending_q != '0) begin
              pending_d = pending_q - PW'(1);
            end
            if (!best_stp_q) begin
              out_valid_d = 1'b1;
              out_kind_d  = RK_FIRED;
              out_seq_d   = best_seq_q;
              out_dl_d    = best_dl_q;
              out_last_d  = 1'b0;
            end
            scan_idx_d = '0;
            issue_d    = 1'b1;
            best_vld_d = 1'b0;
            state_d    = ST_FSCAN;
          end else begin
            out_valid_d = 1'b1;
            out_kind_d  = RK_SUMMARY;
            out_seq_d   = '0;
            out_dl_d    = '0;
            out_last_d  = 1'b1;
            state_d     = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      next_seq_q  <= '0;
      pending_q   <= '0;
      scan_idx_q  <= '0;
      issue_q     <= 1'b0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_seq_q  <= next_seq_d;
      pending_q   <= pending_d;
      scan_idx_q  <= scan_idx_d;
      issue_q     <= issue_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    now_q        <= now_d;
    dl_q         <= dl_d;
    cseq_q       <= cseq_d;
    cmp_idx_q    <= cmp_idx_d;
    best_vld_q   <= best_vld_d;
    best_slot_q  <= best_slot_d;
    best_dl_q    <= best_dl_d;
    best_seq_q   <= best_seq_d;
    best_stp_q   <= best_stp_d;
    free_vld_q   <= free_vld_d;
    free_slot_q  <= free_slot_d;
    match_vld_q  <= match_vld_d;
    match_slot_q <= match_slot_d;
    match_dl_q   <= match_dl_d;
    sum_armed_q  <= sum_armed_d;
    sum_next_q   <= sum_next_d;
    out_kind_q   <= out_kind_d;
    out_seq_q    <= out_seq_d;
    out_dl_q     <= out_dl_d;
    out_armed_q  <= out_armed_d;
    out_next_q   <= out_next_d;
    out_last_q   <= out_last_d;
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[scan_idx_q];
  end

  assign out_valid_o        = out_valid_q;
  assign result_kind_o      = out_kind_q;
  assign res_seq_o          = out_seq_q;
  assign deadline_ms_o      = out_dl_q;
  assign armed_o            = out_armed_q;
  assign next_deadline_ms_o = out_next_q;
  assign last_o             = out_last_q;

  // Checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= FULL_CNT)
    else $error("pending count above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_seq_q != $past(next_seq_q)) |-> (out_valid_o && (result_kind_o == RK_ADDED)))
    else $error("sequence advanced without an added word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q != $past(pending_q)) |->
      ((pending_q == $past(pending_q) + PW'(1)) || (pending_q == $past(pending_q) - PW'(1))))
    else $error("pending count moved by more than one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> ((state_q == ST_SCAN) || (state_q == ST_FSCAN)))
    else $error("slot compare outside a scan");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (result_kind_o == RK_FIRED)) |-> !last_o)
    else $error("fired word marked as last");

endmodule
